[rtl/core/lqs_pkg.sv]
// lqs_pkg: shared constants, codes and the scan word type for the linear queue
// with search. Used by lqs_cell and linear_queue_with_search_core.
// No dependencies.
package lqs_pkg;

    localparam int DEPTH  = 128;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int DATA_W = 32;
    localparam int POS_W  = 7;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [DATA_W-1:0] data_t;

    localparam logic [1:0] REQ_ENQ  = 2'd0;
    localparam logic [1:0] REQ_DEQ  = 2'd1;
    localparam logic [1:0] REQ_SRCH = 2'd2;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_EMPTY    = 2'd2;
    localparam logic [1:0] STAT_NOTFOUND = 2'd3;

    // word that walks down the cell row, one cell per cycle
    typedef struct packed {
        logic  vld;
        logic  srch;
        data_t key;
        idx_t  head;
        idx_t  tail;
        logic  hit;
        idx_t  pos;
        data_t data;
    } tok_t;

endpackage

[rtl/core/lqs_cell.sv]
// lqs_cell: one storage slot of the queue plus one stage of the scan row.
// Compares or reads its slot as the scan word passes by. Depends on lqs_pkg.
module lqs_cell (
    input  logic         clk,
    input  logic         rst_n,
    input  lqs_pkg::idx_t  idx,
    input  logic         wr_en,
    input  lqs_pkg::idx_t  wr_idx,
    input  lqs_pkg::data_t wr_data,
    input  lqs_pkg::tok_t  tok_in,
    output lqs_pkg::tok_t  tok_out
);
    import lqs_pkg::*;

    data_t slot_reg;
    tok_t  tok_reg;
    tok_t  tok_next;
    logic  vld_reg;
    logic  in_rng;

    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_idx == idx))
        begin
            slot_reg <= wr_data;
        end
    end

    always_comb
    begin
        tok_next = tok_in;
        in_rng   = (idx >= tok_in.head) && (idx <= tok_in.tail);
        if (tok_in.vld && in_rng)
        begin
            if (tok_in.srch)
            begin
                // first match wins
                if (!tok_in.hit && (slot_reg == tok_in.key))
                begin
                    tok_next.hit = 1'b1;
                    tok_next.pos = idx;
                end
            end
            else if (idx == tok_in.head)
            begin
                tok_next.data = slot_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= tok_in.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

    always_comb
    begin
        tok_out     = tok_reg;
        tok_out.vld = vld_reg;
    end

endmodule

[rtl/core/linear_queue_with_search_core.sv]
// Enqueue, no-op and requests on an empty queue answer in the cycle after accept.
// Dequeue and search walk the whole cell row plus a hold stage: the injection word,
// every cell register, the hold registers, then the output registers. No new request
// is taken while one is in flight, and a held result stalls the next accept.
// Reset empties the queue (indices zero); slot contents stay undefined until written.
// Depends on lqs_pkg and lqs_cell.
module linear_queue_with_search_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic [1:0]            req_type,
    input  logic signed [31:0]    item_value,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output logic [1:0]            status,
    output logic signed [31:0]    out_value,
    output logic [lqs_pkg::POS_W-1:0] position
);
    import lqs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t state_reg, state_next;
    idx_t   head_reg, head_next;
    idx_t   tail_reg, tail_next;
    logic   empty_reg, empty_next;

    logic   inj_vld_reg, inj_vld_next;
    tok_t   inj_reg, inj_next;

    logic [1:0]       hold_stat_reg, hold_stat_next;
    data_t            hold_data_reg, hold_data_next;
    logic [POS_W-1:0] hold_pos_reg, hold_pos_next;

    logic             rsp_valid_reg, rsp_valid_next;
    logic [1:0]       status_reg, status_next;
    data_t            out_value_reg, out_value_next;
    logic [POS_W-1:0] position_reg, position_next;

    logic   acc;
    logic   out_free;
    logic   ld_out;
    logic   wr_en;
    idx_t   wr_idx;
    logic   full;
    tok_t   tok_first;
    tok_t   tok [0:DEPTH];
    tok_t   tok_last;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != ST_IDLE) || !out_free;
    assign acc       = req_valid && !req_stall;
    assign full      = !empty_reg && (tail_reg == idx_t'(DEPTH - 1));

    always_comb
    begin
        tok_first     = inj_reg;
        tok_first.vld = inj_vld_reg;
    end
    assign tok[0]   = tok_first;
    assign tok_last = tok[DEPTH];

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        lqs_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .idx     (idx_t'(g)),
            .wr_en   (wr_en),
            .wr_idx  (wr_idx),
            .wr_data (data_t'(item_value)),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        empty_next     = empty_reg;
        inj_vld_next   = 1'b0;
        inj_next       = inj_reg;
        hold_stat_next = hold_stat_reg;
        hold_data_next = hold_data_reg;
        hold_pos_next  = hold_pos_reg;
        ld_out         = 1'b0;
        status_next    = status_reg;
        out_value_next = out_value_reg;
        position_next  = position_reg;
        wr_en          = 1'b0;
        wr_idx         = empty_reg ? '0 : idx_t'(tail_reg + idx_t'(1));

        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    inj_next.srch = (req_type == REQ_SRCH);
                    inj_next.key  = data_t'(item_value);
                    inj_next.head = head_reg;
                    inj_next.tail = tail_reg;
                    inj_next.hit  = 1'b0;
                    inj_next.pos  = '0;
                    inj_next.data = '0;
                    out_value_next = '0;
                    position_next  = '0;
                    case (req_type)
                        REQ_ENQ:
                        begin
                            ld_out = 1'b1;
                            if (full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                status_next = STAT_OK;
                                wr_en       = 1'b1;
                                tail_next   = wr_idx;
                                if (empty_reg)
                                begin
                                    head_next  = '0;
                                    empty_next = 1'b0;
                                end
                            end
                        end
                        REQ_DEQ, REQ_SRCH:
                        begin
                            if (empty_reg)
                            begin
                                ld_out      = 1'b1;
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                inj_vld_next = 1'b1;
                                state_next   = ST_SCAN;
                                if (req_type == REQ_DEQ)
                                begin
                                    // indices move now, the slot is read on the way down
                                    if (head_reg == tail_reg)
                                    begin
                                        head_next  = '0;
                                        tail_next  = '0;
                                        empty_next = 1'b1;
                                    end
                                    else
                                    begin
                                        head_next = head_reg + idx_t'(1);
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            ld_out      = 1'b1;
                            status_next = STAT_OK;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (tok_last.vld)
                begin
                    state_next = ST_HOLD;
                    if (tok_last.srch)
                    begin
                        hold_stat_next = tok_last.hit ? STAT_OK : STAT_NOTFOUND;
                        hold_data_next = '0;
                        hold_pos_next  = tok_last.hit ? POS_W'(tok_last.pos) : '0;
                    end
                    else
                    begin
                        hold_stat_next = STAT_OK;
                        hold_data_next = tok_last.data;
                        hold_pos_next  = '0;
                    end
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    ld_out         = 1'b1;
                    status_next    = hold_stat_reg;
                    out_value_next = hold_data_reg;
                    position_next  = hold_pos_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (ld_out)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            empty_reg     <= 1'b1;
            inj_vld_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            empty_reg     <= empty_next;
            inj_vld_reg   <= inj_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        inj_reg       <= inj_next;
        hold_stat_reg <= hold_stat_next;
        hold_data_reg <= hold_data_next;
        hold_pos_reg  <= hold_pos_next;
        if (ld_out)
        begin
            status_reg    <= status_next;
            out_value_reg <= out_value_next;
            position_reg  <= position_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign out_value = $signed(out_value_reg);
    assign position  = position_reg;

endmodule
